// ===== hdl/query_token_boundary_lexer_top_macros.svh =====
// Assertion macros shared by the lexer checker.
`ifndef QUERY_TOKEN_BOUNDARY_LEXER_TOP_MACROS_SVH
`define QUERY_TOKEN_BOUNDARY_LEXER_TOP_MACROS_SVH

// Check a property on the rising clock edge, ignored while reset is held.
`define QTBL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock edge, reset cycles included.
`define QTBL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/qtbl_pkg.sv =====
// Types, character codes and byte classes for the query token boundary lexer.
`timescale 1ns / 1ps

package qtbl_pkg;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [10:0] {
    MODE_IDLE    = 11'b000_0000_0001,
    MODE_COMMENT = 11'b000_0000_0010,
    MODE_IRI     = 11'b000_0000_0100,
    MODE_Q1      = 11'b000_0000_1000,
    MODE_Q2      = 11'b000_0001_0000,
    MODE_SHORT   = 11'b000_0010_0000,
    MODE_LONG    = 11'b000_0100_0000,
    MODE_VAR     = 11'b000_1000_0000,
    MODE_CARET   = 11'b001_0000_0000,
    MODE_WORD    = 11'b010_0000_0000,
    MODE_TAIL    = 11'b100_0000_0000
  } qtbl_mode_t;

  typedef struct packed {
    qtbl_mode_t mode;
    logic       esc;         // next byte is escaped
    logic       qkind;       // 1 single quote, 0 double quote
    logic [1:0] qrun;        // closing quotes seen in a row
    logic       int_so_far;  // word so far is [+-]?[0-9]*
    logic       digit_seen;
  } qtbl_state_t;

  typedef struct packed {
    logic [7:0] token_byte;
    logic       byte_valid;
    logic       token_start;
  } qtbl_result_t;

  localparam qtbl_state_t STATE_RESET = '{
    mode: MODE_IDLE, esc: 1'b0, qkind: 1'b0, qrun: 2'd0, int_so_far: 1'b0, digit_seen: 1'b0
  };

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_FF) || (b == CH_LF) || (b == CH_CR) ||
           (b == CH_TAB) || (b == CH_VT);
  endfunction

  function automatic logic is_delim(input logic [7:0] b);
    return (b == CH_LT) || (b == CH_GT) || (b == CH_SQUOTE) || (b == CH_DQUOTE) ||
           (b == CH_QMARK) || (b == CH_DOLLAR) || (b == CH_COMMA) || (b == CH_SEMI) ||
           (b == CH_DOT) || (b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_LBRACK) ||
           (b == CH_RBRACK) || (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_AT);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

// ===== hdl/query_token_boundary_lexer_top.sv =====
// An accepted item passes through the input register and then the result register to the output.
// Throughput: one item per cycle while the pipeline advances; the lexer state register closes a loop.
// The pipeline advances while the result register is empty or being taken.
// Reset (rst_n low, synchronous): both registers empty, lexer idle between tokens.
// The item that carries tlast also returns the lexer to its reset state.
`timescale 1ns / 1ps

module query_token_boundary_lexer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // final_req
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] token_byte
  output logic [1:0] out_tuser,  // [0] byte_valid, [1] token_start
  output logic       out_tlast   // end_of_stream
);

  logic                   in_valid_r;
  logic                   in_valid_nxt;
  logic [7:0]             in_byte_r;
  logic                   in_last_r;
  qtbl_pkg::qtbl_state_t  state_r;
  qtbl_pkg::qtbl_state_t  state_nxt;
  qtbl_pkg::qtbl_result_t step_res;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [7:0]             out_byte_r;
  logic [1:0]             out_flags_r;
  logic                   out_last_r;
  logic                   advance;
  logic                   fire;
  logic                   in_take;

  qtbl_step u_step (
    .st        (state_r),
    .data_byte (in_byte_r),
    .final_req (in_last_r),
    .st_nxt    (state_nxt),
    .res       (step_res)
  );

  assign advance       = !out_valid_r || out_tready;
  assign fire          = in_valid_r && advance;
  assign in_tready     = !in_valid_r || advance;
  assign in_take       = in_tvalid && in_tready;
  assign in_valid_nxt  = in_take || (in_valid_r && !advance);
  assign out_valid_nxt = fire || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= qtbl_pkg::STATE_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (fire) begin
      out_byte_r  <= step_res.token_byte;
      out_flags_r <= {step_res.token_start, step_res.byte_valid};
      out_last_r  <= in_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_flags_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== hdl/qtbl_step.sv =====
// Next-state and result logic of the lexer for one byte.
`timescale 1ns / 1ps

module qtbl_step (
  input  qtbl_pkg::qtbl_state_t  st,
  input  logic [7:0]             data_byte,
  input  logic                   final_req,
  output qtbl_pkg::qtbl_state_t  st_nxt,
  output qtbl_pkg::qtbl_result_t res
);

  qtbl_pkg::qtbl_state_t nxt;
  logic       valid;
  logic       start;
  logic       restart;
  logic [7:0] qc;
  logic       boundary;

  assign qc       = st.qkind ? qtbl_pkg::CH_SQUOTE : qtbl_pkg::CH_DQUOTE;
  assign boundary = qtbl_pkg::is_blank(data_byte) || qtbl_pkg::is_delim(data_byte);

  always_comb begin
    nxt     = st;
    valid   = 1'b1;
    start   = 1'b0;
    restart = 1'b0;

    unique case (st.mode)
      qtbl_pkg::MODE_COMMENT: begin
        valid = 1'b0;
        if (st.esc) begin
          nxt.esc = 1'b0;
        end else if (data_byte == qtbl_pkg::CH_LF || data_byte == qtbl_pkg::CH_CR) begin
          nxt.mode = qtbl_pkg::MODE_IDLE;
        end else if (data_byte == qtbl_pkg::CH_BSLASH) begin
          nxt.esc = 1'b1;
        end
      end
      qtbl_pkg::MODE_IRI: begin
        if (st.esc) begin
          nxt.esc = 1'b0;
        end else if (data_byte == qtbl_pkg::CH_GT) begin
          nxt.mode = qtbl_pkg::MODE_IDLE;
        end else if (data_byte == qtbl_pkg::CH_BSLASH) begin
          nxt.esc = 1'b1;
        end
      end
      qtbl_pkg::MODE_Q1: begin
        if (data_byte == qc) begin
          nxt.mode = qtbl_pkg::MODE_Q2;
        end else begin
          nxt.mode = qtbl_pkg::MODE_SHORT;
          nxt.esc  = (data_byte == qtbl_pkg::CH_BSLASH);
        end
      end
      qtbl_pkg::MODE_Q2: begin
        // third quote opens a long string, anything else closes an empty one
        if (data_byte == qc) begin
          nxt.mode = qtbl_pkg::MODE_LONG;
          nxt.qrun = 2'd0;
          nxt.esc  = 1'b0;
        end else begin
          restart = 1'b1;
        end
      end
      qtbl_pkg::MODE_SHORT: begin
        if (st.esc) begin
          nxt.esc = 1'b0;
        end else if (data_byte == qc) begin
          nxt.mode = qtbl_pkg::MODE_IDLE;
        end else if (data_byte == qtbl_pkg::CH_BSLASH) begin
          nxt.esc = 1'b1;
        end
      end
      qtbl_pkg::MODE_LONG: begin
        if (st.esc) begin
          nxt.esc  = 1'b0;
          nxt.qrun = 2'd0;
        end else if (data_byte == qc) begin
          if (st.qrun == 2'd2) begin
            nxt.qrun = 2'd0;
            nxt.mode = qtbl_pkg::MODE_IDLE;
          end else begin
            nxt.qrun = st.qrun + 2'd1;
          end
        end else begin
          nxt.qrun = 2'd0;
          if (data_byte == qtbl_pkg::CH_BSLASH) begin
            nxt.esc = 1'b1;
          end
        end
      end
      qtbl_pkg::MODE_CARET: begin
        if (data_byte == qtbl_pkg::CH_CARET) begin
          nxt.mode = qtbl_pkg::MODE_IDLE;
        end else begin
          restart = 1'b1;
        end
      end
      qtbl_pkg::MODE_VAR, qtbl_pkg::MODE_WORD, qtbl_pkg::MODE_TAIL: begin
        if (st.esc) begin
          nxt.esc = 1'b0;
        end else if (boundary) begin
          // an integer word swallows one dot and runs on
          if (st.mode == qtbl_pkg::MODE_WORD && data_byte == qtbl_pkg::CH_DOT &&
              st.int_so_far && st.digit_seen) begin
            nxt.mode = qtbl_pkg::MODE_TAIL;
          end else begin
            restart = 1'b1;
          end
        end else if (data_byte == qtbl_pkg::CH_BSLASH) begin
          nxt.esc        = 1'b1;
          nxt.int_so_far = 1'b0;
        end else if (st.mode == qtbl_pkg::MODE_WORD) begin
          if (qtbl_pkg::is_digit(data_byte)) begin
            nxt.digit_seen = 1'b1;
          end else begin
            nxt.int_so_far = 1'b0;
          end
        end
      end
      default: begin
        restart = 1'b1;
      end
    endcase

    if (restart) begin
      nxt.esc  = 1'b0;
      nxt.qrun = 2'd0;
      nxt.mode = qtbl_pkg::MODE_IDLE;
      valid    = 1'b1;
      if (qtbl_pkg::is_blank(data_byte)) begin
        valid = 1'b0;
      end else begin
        unique case (data_byte)
          qtbl_pkg::CH_HASH: begin
            nxt.mode = qtbl_pkg::MODE_COMMENT;
            valid    = 1'b0;
          end
          qtbl_pkg::CH_LT: begin
            nxt.mode = qtbl_pkg::MODE_IRI;
          end
          qtbl_pkg::CH_DQUOTE, qtbl_pkg::CH_SQUOTE: begin
            nxt.qkind = (data_byte == qtbl_pkg::CH_SQUOTE);
            nxt.mode  = qtbl_pkg::MODE_Q1;
          end
          qtbl_pkg::CH_QMARK, qtbl_pkg::CH_DOLLAR, qtbl_pkg::CH_AT: begin
            nxt.mode = qtbl_pkg::MODE_VAR;
          end
          qtbl_pkg::CH_CARET: begin
            nxt.mode = qtbl_pkg::MODE_CARET;
          end
          qtbl_pkg::CH_DOT, qtbl_pkg::CH_SEMI, qtbl_pkg::CH_COMMA, qtbl_pkg::CH_LPAREN,
          qtbl_pkg::CH_RPAREN, qtbl_pkg::CH_LBRACK, qtbl_pkg::CH_RBRACK,
          qtbl_pkg::CH_LBRACE, qtbl_pkg::CH_RBRACE: begin
            nxt.mode = qtbl_pkg::MODE_IDLE;
          end
          default: begin
            nxt.mode       = qtbl_pkg::MODE_WORD;
            nxt.int_so_far = data_byte == qtbl_pkg::CH_PLUS ||
                             data_byte == qtbl_pkg::CH_MINUS ||
                             qtbl_pkg::is_digit(data_byte);
            nxt.digit_seen = qtbl_pkg::is_digit(data_byte);
          end
        endcase
      end
      start = valid;
    end

    // the last byte of a stream returns the lexer to its reset state
    st_nxt          = final_req ? qtbl_pkg::STATE_RESET : nxt;
    res.token_byte  = valid ? data_byte : 8'h00;
    res.byte_valid  = valid;
    res.token_start = start;
  end

endmodule

// ===== hdl/qtbl_checker.sv =====
// Port-level checks for the lexer, bound to the top level.
`timescale 1ns / 1ps
`include "query_token_boundary_lexer_top_macros.svh"

module qtbl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  logic blank_out;

  assign blank_out = out_tdata == 8'h20 || out_tdata == 8'h09 || out_tdata == 8'h0A ||
                     out_tdata == 8'h0B || out_tdata == 8'h0C || out_tdata == 8'h0D;

  // hold a stalled item
  `QTBL_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled output item changed")

  // a dropped byte reads as zero and never starts a token
  `QTBL_ASSERT(a_drop_clean, out_tvalid && !out_tuser[0] |-> out_tdata == 8'h00 && !out_tuser[1], "dropped item carries data or start")

  // whitespace never reaches the output as a token start
  `QTBL_ASSERT(a_start_not_blank, out_tvalid && out_tuser[1] |-> !blank_out && out_tuser[0], "token start on whitespace")

  // nothing leaves straight after reset
  `QTBL_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid, "output valid after reset")

  // the input side may always take an item while the output drains
  `QTBL_ASSERT(a_ready_drain, out_tready |-> in_tready, "input stalled while output drains")

endmodule

bind query_token_boundary_lexer_top qtbl_checker u_qtbl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== tb/qtbl_lex_checker.sv =====
// Checker for the query token boundary lexer: predicts each result and compares it.
`timescale 1ns / 1ps

module qtbl_lex_checker
  import qtbl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // final_req
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [7:0] token_byte
  input  logic [1:0] out_tuser,  // [0] byte_valid, [1] token_start
  input  logic       out_tlast,  // end_of_stream
  output int         mismatches,
  output int         results_owed,
  output int         tokens_seen
);

  typedef struct packed {
    logic [7:0] tok;
    logic       kept;
    logic       first;
    logic       eos;
  } lexed_t;

  qtbl_mode_t mode_q;
  logic       esc_q;
  logic       single_q;
  logic [1:0] run_q;
  logic       int_q;
  logic       digit_q;
  lexed_t     owed_q[$];
  int         errs = 0;
  int         starts = 0;

  function automatic void clear_state();
    mode_q   = MODE_IDLE;
    esc_q    = 1'b0;
    single_q = 1'b0;
    run_q    = 2'd0;
    int_q    = 1'b0;
    digit_q  = 1'b0;
  endfunction

  function automatic logic blank_b(input logic [7:0] b);
    case (b)
      CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic stops_word(input logic [7:0] b);
    case (b)
      CH_LT, CH_GT, CH_SQUOTE, CH_DQUOTE, CH_QMARK, CH_DOLLAR, CH_COMMA, CH_SEMI,
      CH_DOT, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE,
      CH_AT: return 1'b1;
      default: return blank_b(b);
    endcase
  endfunction

  function automatic logic digit_b(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // Take b as the first byte of a token; return whether it is kept.
  function automatic logic open_token(input logic [7:0] b);
    esc_q  = 1'b0;
    run_q  = 2'd0;
    mode_q = MODE_IDLE;
    open_token = 1'b1;
    if (blank_b(b)) begin
      open_token = 1'b0;
    end else begin
      case (b)
        CH_HASH: begin
          mode_q = MODE_COMMENT;
          open_token = 1'b0;
        end
        CH_LT: mode_q = MODE_IRI;
        CH_DQUOTE, CH_SQUOTE: begin
          single_q = (b == CH_SQUOTE);
          mode_q = MODE_Q1;
        end
        CH_QMARK, CH_DOLLAR, CH_AT: mode_q = MODE_VAR;
        CH_CARET: mode_q = MODE_CARET;
        CH_DOT, CH_SEMI, CH_COMMA, CH_LPAREN, CH_RPAREN,
        CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE: ;
        default: begin
          mode_q  = MODE_WORD;
          int_q   = (b == CH_PLUS) || (b == CH_MINUS) || digit_b(b);
          digit_q = digit_b(b);
        end
      endcase
    end
  endfunction

  function automatic lexed_t lex_item(input logic [7:0] b, input logic fin);
    logic [7:0] quote;
    logic       restart;
    lexed_t     r;
    quote   = single_q ? CH_SQUOTE : CH_DQUOTE;
    restart = 1'b0;
    r.kept  = 1'b1;
    r.first = 1'b0;
    case (mode_q)
      MODE_COMMENT: begin
        r.kept = 1'b0;
        if (esc_q) esc_q = 1'b0;
        else if (b == CH_LF || b == CH_CR) mode_q = MODE_IDLE;
        else if (b == CH_BSLASH) esc_q = 1'b1;
      end
      MODE_IRI: begin
        if (esc_q) esc_q = 1'b0;
        else if (b == CH_GT) mode_q = MODE_IDLE;
        else if (b == CH_BSLASH) esc_q = 1'b1;
      end
      MODE_Q1: begin
        if (b == quote) begin
          mode_q = MODE_Q2;
        end else begin
          mode_q = MODE_SHORT;
          esc_q = (b == CH_BSLASH);
        end
      end
      MODE_Q2: begin
        if (b == quote) begin
          mode_q = MODE_LONG;
          run_q = 2'd0;
          esc_q = 1'b0;
        end else begin
          // empty string: this byte opens the next token
          restart = 1'b1;
        end
      end
      MODE_SHORT: begin
        if (esc_q) esc_q = 1'b0;
        else if (b == quote) mode_q = MODE_IDLE;
        else if (b == CH_BSLASH) esc_q = 1'b1;
      end
      MODE_LONG: begin
        if (esc_q) begin
          esc_q = 1'b0;
          run_q = 2'd0;
        end else if (b == quote) begin
          if (run_q == 2'd2) begin
            run_q = 2'd0;
            mode_q = MODE_IDLE;
          end else begin
            run_q = run_q + 2'd1;
          end
        end else begin
          run_q = 2'd0;
          if (b == CH_BSLASH) esc_q = 1'b1;
        end
      end
      MODE_CARET: begin
        if (b == CH_CARET) mode_q = MODE_IDLE;
        else restart = 1'b1;
      end
      MODE_VAR, MODE_WORD, MODE_TAIL: begin
        if (esc_q) begin
          esc_q = 1'b0;
        end else if (stops_word(b)) begin
          // an integer so far swallows one dot and runs on
          if (mode_q == MODE_WORD && b == CH_DOT && int_q && digit_q) mode_q = MODE_TAIL;
          else restart = 1'b1;
        end else if (b == CH_BSLASH) begin
          esc_q = 1'b1;
          int_q = 1'b0;
        end else if (mode_q == MODE_WORD) begin
          if (digit_b(b)) digit_q = 1'b1;
          else int_q = 1'b0;
        end
      end
      default: restart = 1'b1;
    endcase
    if (restart) begin
      r.kept  = open_token(b);
      r.first = r.kept;
    end
    r.tok = r.kept ? b : 8'h00;
    r.eos = fin;
    if (fin) clear_state();
    return r;
  endfunction

  always @(posedge clk) begin
    lexed_t want;
    if (!rst_n) begin
      clear_state();
      owed_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (owed_q.size() == 0) begin
          errs++;
          $error("result with no item pending: token_byte %02h", out_tdata);
        end else begin
          want = owed_q.pop_front();
          if (out_tdata !== want.tok) begin
            errs++;
            $error("token_byte: expected %02h, got %02h", want.tok, out_tdata);
          end
          if (out_tuser[0] !== want.kept) begin
            errs++;
            $error("byte_valid: expected %0b, got %0b", want.kept, out_tuser[0]);
          end
          if (out_tuser[1] !== want.first) begin
            errs++;
            $error("token_start: expected %0b, got %0b", want.first, out_tuser[1]);
          end
          if (out_tlast !== want.eos) begin
            errs++;
            $error("end_of_stream: expected %0b, got %0b", want.eos, out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want = lex_item(in_tdata, in_tlast);
        starts += want.first;
        owed_q.push_back(want);
      end
    end
    mismatches   <= errs;
    results_owed <= owed_q.size();
    tokens_seen  <= starts;
  end

endmodule

// ===== tb/tb_query_token_boundary_lexer_top.sv =====
// Testbench top for the query token boundary lexer: stimulus, output pacing and verdict.
`timescale 1ns / 1ps

module tb_query_token_boundary_lexer_top;
  import qtbl_pkg::*;

  localparam int ITEM_TARGET = 1300;
  localparam int STALL_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tready = 1'b0;
  wire        in_tready;
  wire        out_tvalid;
  wire  [7:0] out_tdata;
  wire  [1:0] out_tuser;
  wire        out_tlast;

  int   mismatches;
  int   results_owed;
  int   tokens_seen;
  int   bytes_sent = 0;
  int   queries_sent = 0;
  int   drains = 0;
  int   idle_cycles = 0;
  int   hold_left = 0;
  logic burst = 1'b0;
  logic sink_eager = 1'b0;

  logic [7:0] text_q[$];

  // Opening query: NUL and 0xFF in a word, integer with dot, double caret, comment with
  // escaped LF, IRI with escaped '>', empty string, variable, unterminated final comment.
  logic [7:0] seed_text [24] = '{
    8'h00, 8'hFF, CH_SPACE, CH_MINUS, 8'h37, CH_DOT, 8'h78, CH_CARET,
    CH_CARET, CH_HASH, CH_BSLASH, CH_LF, CH_CR, CH_LT, CH_BSLASH, CH_GT,
    CH_GT, CH_DQUOTE, CH_DQUOTE, CH_QMARK, 8'h76, CH_SEMI, CH_HASH, 8'h7A
  };
  logic [7:0] marks [9] = '{
    CH_DOT, CH_SEMI, CH_COMMA, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE,
    CH_RBRACE
  };
  logic [7:0] blanks [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
  logic [7:0] odd_chars [6] = '{8'h5F, 8'h3A, CH_HASH, CH_CARET, CH_PLUS, 8'h00};

  query_token_boundary_lexer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  qtbl_lex_checker lex_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .mismatches   (mismatches),
    .results_owed (results_owed),
    .tokens_seen  (tokens_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Output pacing: mostly ready, short stalls, now and then a long one.
  always @(posedge clk) begin : sink_pace
    int pick;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (sink_eager || pick < 60) begin
        out_tready <= 1'b1;
        hold_left  <= $urandom_range(0, 15);
      end else if (pick < 95) begin
        out_tready <= 1'b0;
        hold_left  <= $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b0;
        hold_left  <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $error("no item moved for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic last);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (burst || pick < 70) gap = 0;
    else if (pick < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_query();
    burst = ($urandom_range(0, 3) == 0);
    sink_eager <= ($urandom_range(0, 3) == 0);
    for (int i = 0; i < text_q.size(); i++) send_item(text_q[i], i == text_q.size() - 1);
    text_q.delete();
    queries_sent++;
  endtask

  // Hold the input until every outstanding result has been taken.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  function automatic logic [7:0] plain_byte();
    case ($urandom_range(0, 5))
      0, 1: return 8'($urandom_range(8'h61, 8'h7A));
      2: return 8'($urandom_range(CH_ZERO, CH_NINE));
      3: return 8'($urandom_range(8'h80, 8'hFF));
      default: return odd_chars[$urandom_range(0, 5)];
    endcase
  endfunction

  // Append a body byte that is neither stop byte, or an escape pair.
  task automatic add_body_byte(input logic [7:0] stop_a, input logic [7:0] stop_b);
    logic [7:0] b;
    if ($urandom_range(0, 6) == 0) begin
      text_q.push_back(CH_BSLASH);
      text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      do b = 8'($urandom_range(0, 255)); while (b == stop_a || b == stop_b || b == CH_BSLASH);
      text_q.push_back(b);
    end
  endtask

  task automatic add_token();
    logic [7:0] q;
    q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
    case ($urandom_range(0, 11))
      0: begin
        text_q.push_back(CH_LT);
        repeat ($urandom_range(0, 6)) add_body_byte(CH_GT, CH_GT);
        text_q.push_back(CH_GT);
      end
      1, 2: begin
        text_q.push_back(q);
        repeat ($urandom_range(0, 6)) add_body_byte(q, q);
        text_q.push_back(q);
      end
      3: begin
        repeat (3) text_q.push_back(q);
        repeat ($urandom_range(0, 6)) begin
          // one or two unescaped quotes inside, never three in a row
          if ($urandom_range(0, 5) == 0) text_q.push_back(q);
          if ($urandom_range(0, 9) == 0) text_q.push_back(q);
          add_body_byte(q, q);
        end
        repeat (3) text_q.push_back(q);
      end
      4, 5: begin
        if ($urandom_range(0, 1) == 0) begin
          if ($urandom_range(0, 1)) text_q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
          repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
          if ($urandom_range(0, 1)) begin
            text_q.push_back(CH_DOT);
            repeat ($urandom_range(0, 3)) text_q.push_back(plain_byte());
          end
        end else begin
          text_q.push_back(plain_byte());
          repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 9) == 0) begin
              text_q.push_back(CH_BSLASH);
              text_q.push_back(8'($urandom_range(0, 255)));
            end else begin
              text_q.push_back(plain_byte());
            end
          end
        end
      end
      6: begin
        case ($urandom_range(0, 2))
          0: text_q.push_back(CH_QMARK);
          1: text_q.push_back(CH_DOLLAR);
          default: text_q.push_back(CH_AT);
        endcase
        repeat ($urandom_range(0, 5)) text_q.push_back(plain_byte());
      end
      7: begin
        text_q.push_back(CH_CARET);
        if ($urandom_range(0, 1)) text_q.push_back(CH_CARET);
      end
      8: text_q.push_back(marks[$urandom_range(0, 8)]);
      9: begin
        text_q.push_back(CH_HASH);
        repeat ($urandom_range(0, 8)) add_body_byte(CH_LF, CH_CR);
        text_q.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
      end
      10: repeat ($urandom_range(1, 3)) text_q.push_back(blanks[$urandom_range(0, 5)]);
      default: text_q.push_back(8'($urandom_range(0, 255)));
    endcase
    if ($urandom_range(0, 2) != 0) text_q.push_back(blanks[$urandom_range(0, 5)]);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (seed_text[i]) text_q.push_back(seed_text[i]);
    send_query();
    while (bytes_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 20)) text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 12)) add_token();
        // cut the tail so that the final byte lands inside a token
        if ($urandom_range(0, 4) == 0 && text_q.size() > 2)
          repeat ($urandom_range(1, 2)) void'(text_q.pop_back());
      end
      send_query();
      if (queries_sent % 15 == 0) begin
        drain_results();
        drains++;
      end
    end
    drain_results();
    repeat (4) @(posedge clk);
    $display("covered %0d bytes over %0d queries, %0d token starts, %0d full drains",
             bytes_sent, queries_sent, tokens_seen, drains);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
